### sv/rclt_pkg.sv
// Package for the region cache LRU tracker: constants, operation codes,
// the state encoding and the layout of one cache entry. No dependencies.
`default_nettype none
package rclt_pkg;

  localparam int unsigned EntriesDef    = 1024;
  localparam int unsigned KeyW          = 32;
  localparam int unsigned OffW          = 48;
  localparam int unsigned SizeW         = 32;
  localparam int unsigned StampW        = 48;
  localparam int unsigned UsedW         = 48;
  localparam int unsigned CntOutW       = 11;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 48;

  localparam logic [UsedW-1:0]   BudgetRst  = 48'd268435456;
  localparam logic [CntOutW-1:0] MaxEntRst  = 11'd1024;
  localparam logic [UsedW-1:0]   UsedMax    = {UsedW{1'b1}};

  localparam logic [CfgIdxW-1:0] CfgBudget  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxEnt  = 2'd1;

  typedef enum logic [1:0] {
    FnRead     = 2'd0,
    FnPrefetch = 2'd1,
    FnQuery    = 2'd2,
    FnEvict    = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StLook,
    StEvChk,
    StLru,
    StEvWr,
    StFillChk,
    StFree,
    StWr,
    StDone
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [OffW-1:0]   offset;
    logic [SizeW-1:0]  nbytes;
    logic [StampW-1:0] stamp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage
`default_nettype wire

### sv/rclt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module rclt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### sv/region_cache_lru_tracker_top.sv
// Top level of the region cache LRU tracker: control sequencer, counters and
// result registers around one entry RAM. Uses rclt_pkg and rclt_ram.
//
// A fully associative region metadata cache held in one RAM of ENTRIES words,
// walked one word per cycle. After reset a clearing pass writes every word
// before the first request beat is taken. Reads and prefetches of nonzero size
// and all queries then make a lookup sweep. A fill miss then passes, for each
// eviction, through a budget check, an LRU sweep and an eviction write,
// followed by a last check and a free-slot sweep over the first limit slots.
// An explicit evict on a non-empty cache costs one LRU sweep and a write. The
// single RAM read port makes every search a sweep. Configuration writes are
// always taken and must only be made while the block is idle.
`default_nettype none
module region_cache_lru_tracker_top
  import rclt_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           func_i,
  input  wire logic [KeyW-1:0]      name_key_i,
  input  wire logic [OffW-1:0]      region_offset_i,
  input  wire logic [SizeW-1:0]     region_size_i,
  input  wire logic                 cache_fill_i,
  input  wire logic [SizeW-1:0]     fetched_bytes_i,
  input  wire logic [StampW-1:0]    now_time_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      status_o,
  output logic [SizeW-1:0]          bytes_returned_o,
  output logic                      hit_o,
  output logic [CntOutW-1:0]        evicted_count_o,
  output logic                      cached_o,
  output logic [UsedW-1:0]          used_bytes_o,
  output logic [CntOutW-1:0]        entry_count_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  // control state
  state_e          state_q, state_d;
  logic [IW-1:0]   clr_q, clr_d;
  logic [IW-1:0]   iss_q, iss_d;
  logic            iss_done_q, iss_done_d;
  logic            pend_q, pend_d;
  logic [IW-1:0]   pidx_q, pidx_d;
  logic [IW-1:0]   last_q, last_d;
  logic [UsedW-1:0] used_q, used_d;
  logic [CW-1:0]   count_q, count_d;
  logic [UsedW-1:0] budget_q, budget_d;
  logic [CntOutW-1:0] maxent_q, maxent_d;
  logic            out_valid_q, out_valid_d;

  // request and working payload
  func_e           op_q, op_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [OffW-1:0] off_q, off_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [SizeW-1:0] n_q, n_d;
  logic            fill_q, fill_d;
  logic [StampW-1:0] now_q, now_d;
  logic            best_found_q, best_found_d;
  logic [IW-1:0]   best_idx_q, best_idx_d;
  logic [StampW-1:0] best_stamp_q, best_stamp_d;
  logic [SizeW-1:0] best_bytes_q, best_bytes_d;
  logic [IW-1:0]   wr_idx_q, wr_idx_d;
  entry_t          wr_ent_q, wr_ent_d;
  logic            r_status_q, r_status_d;
  logic [SizeW-1:0] r_bytes_q, r_bytes_d;
  logic            r_hit_q, r_hit_d;
  logic [CW-1:0]   r_evc_q, r_evc_d;
  logic            r_cached_q, r_cached_d;

  // output registers
  logic            o_status_q, o_status_d;
  logic [SizeW-1:0] o_bytes_q, o_bytes_d;
  logic            o_hit_q, o_hit_d;
  logic [CW-1:0]   o_evc_q, o_evc_d;
  logic            o_cached_q, o_cached_d;
  logic [UsedW-1:0] o_used_q, o_used_d;
  logic [CW-1:0]   o_count_q, o_count_d;

  // RAM port
  logic            ram_we, ram_re;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  entry_t          ram_wdata, rd;
  logic [EntryW-1:0] ram_rdata;

  logic [CW-1:0]   lim;
  logic            in_fire, scan_end, match;
  logic [UsedW:0]  need_sum, add_sum;

  assign rd = entry_t'(ram_rdata);

  rclt_ram #(
    .WIDTH (EntryW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (EntryW'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // out-of-range limit falls back to the full depth
  always_comb begin
    if (maxent_q == '0 || 32'(maxent_q) > ENTRIES) begin
      lim = CW'(ENTRIES);
    end else begin
      lim = CW'(maxent_q);
    end
  end

  assign need_sum  = {1'b0, used_q} + (UsedW+1)'(size_q);
  assign add_sum   = {1'b0, used_q} + (UsedW+1)'(n_q);
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign scan_end  = pend_q && (pidx_q == last_q);
  assign match     = rd.valid && (rd.key == key_q) &&
                     ((op_q == FnQuery) || (rd.offset == off_q));

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    iss_d        = iss_q;
    iss_done_d   = iss_done_q;
    pend_d       = 1'b0;
    pidx_d       = pidx_q;
    last_d       = last_q;
    used_d       = used_q;
    count_d      = count_q;
    budget_d     = budget_q;
    maxent_d     = maxent_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    key_d        = key_q;
    off_d        = off_q;
    size_d       = size_q;
    n_d          = n_q;
    fill_d       = fill_q;
    now_d        = now_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    best_bytes_d = best_bytes_q;
    wr_idx_d     = wr_idx_q;
    wr_ent_d     = wr_ent_q;
    r_status_d   = r_status_q;
    r_bytes_d    = r_bytes_q;
    r_hit_d      = r_hit_q;
    r_evc_d      = r_evc_q;
    r_cached_d   = r_cached_q;
    o_status_d   = o_status_q;
    o_bytes_d    = o_bytes_q;
    o_hit_d      = o_hit_q;
    o_evc_d      = o_evc_q;
    o_cached_d   = o_cached_q;
    o_used_d     = o_used_q;
    o_count_d    = o_count_q;
    ram_we       = 1'b0;
    ram_waddr    = wr_idx_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = iss_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBudget: budget_d = cfg_data_i[UsedW-1:0];
        CfgMaxEnt: maxent_d = cfg_data_i[CntOutW-1:0];
        default:   ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // read issue for the sweeping states
    if (state_q == StLook || state_q == StLru || state_q == StFree) begin
      if (!iss_done_q) begin
        ram_re = 1'b1;
        pend_d = 1'b1;
        pidx_d = iss_q;
        if (iss_q == last_q) begin
          iss_done_d = 1'b1;
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end
    end

    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == LastIdx) begin
          state_d = StIdle;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      StIdle: begin
        if (in_fire) begin
          op_d       = func_e'(func_i);
          key_d      = name_key_i;
          off_d      = region_offset_i;
          size_d     = region_size_i;
          n_d        = (fetched_bytes_i < region_size_i) ? fetched_bytes_i : region_size_i;
          fill_d     = cache_fill_i || (func_e'(func_i) == FnPrefetch);
          now_d      = now_time_i;
          r_status_d = 1'b0;
          r_bytes_d  = '0;
          r_hit_d    = 1'b0;
          r_evc_d    = '0;
          r_cached_d = 1'b0;
          iss_d      = '0;
          iss_done_d = 1'b0;
          last_d     = LastIdx;
          best_found_d = 1'b0;
          case (func_e'(func_i))
            FnRead: begin
              state_d = (region_size_i == '0) ? StDone : StLook;
            end
            FnPrefetch: begin
              if (region_size_i == '0) begin
                r_status_d = 1'b1;
                state_d    = StDone;
              end else begin
                state_d = StLook;
              end
            end
            FnQuery: state_d = StLook;
            default: state_d = (count_q == '0) ? StDone : StLru;
          endcase
        end
      end

      StLook: begin
        if (pend_q && match) begin
          case (op_q)
            FnRead: begin
              r_hit_d        = 1'b1;
              r_bytes_d      = size_q;
              wr_idx_d       = pidx_q;
              wr_ent_d       = rd;
              wr_ent_d.stamp = now_q;
              state_d        = StWr;
            end
            FnPrefetch: begin
              r_hit_d = 1'b1;
              state_d = StDone;
            end
            default: begin
              r_cached_d = 1'b1;
              state_d    = StDone;
            end
          endcase
        end else if (scan_end) begin
          state_d = (op_q == FnQuery) ? StDone : StEvChk;
        end
      end

      StEvChk: begin
        iss_d        = '0;
        iss_done_d   = 1'b0;
        last_d       = LastIdx;
        best_found_d = 1'b0;
        if (fill_q && (need_sum > {1'b0, budget_q}) && (count_q != '0)) begin
          state_d = StLru;
        end else begin
          state_d = StFillChk;
        end
      end

      StLru: begin
        // strict less-than keeps the lowest slot on equal stamps
        if (pend_q && rd.valid && (!best_found_q || rd.stamp < best_stamp_q)) begin
          best_found_d = 1'b1;
          best_idx_d   = pidx_q;
          best_stamp_d = rd.stamp;
          best_bytes_d = rd.nbytes;
        end
        if (scan_end) begin
          if (best_found_d) begin
            state_d = StEvWr;
          end else begin
            state_d = (op_q == FnEvict) ? StDone : StFillChk;
          end
        end
      end

      StEvWr: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_q;
        if (used_q >= UsedW'(best_bytes_q)) begin
          used_d = used_q - UsedW'(best_bytes_q);
        end else begin
          used_d = '0;
        end
        count_d = count_q - 1'b1;
        r_evc_d = r_evc_q + 1'b1;
        if (op_q == FnEvict) begin
          r_cached_d = 1'b1;
          state_d    = StDone;
        end else begin
          state_d = StEvChk;
        end
      end

      StFillChk: begin
        iss_d      = '0;
        iss_done_d = 1'b0;
        last_d     = IW'(lim - 1'b1);
        if (n_q == '0) begin
          r_bytes_d = '0;
          state_d   = StDone;
        end else begin
          r_bytes_d = n_q;
          state_d   = (fill_q && count_q < lim) ? StFree : StDone;
        end
      end

      StFree: begin
        if (pend_q && !rd.valid) begin
          wr_idx_d        = pidx_q;
          wr_ent_d.valid  = 1'b1;
          wr_ent_d.key    = key_q;
          wr_ent_d.offset = off_q;
          wr_ent_d.nbytes = n_q;
          wr_ent_d.stamp  = now_q;
          count_d         = count_q + 1'b1;
          used_d          = add_sum[UsedW] ? UsedMax : add_sum[UsedW-1:0];
          state_d         = StWr;
        end else if (scan_end) begin
          state_d = StDone;
        end
      end

      StWr: begin
        ram_we    = 1'b1;
        ram_waddr = wr_idx_q;
        ram_wdata = wr_ent_q;
        state_d   = StDone;
      end

      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          o_status_d  = (op_q == FnPrefetch && !r_hit_q) ? (r_bytes_q == '0) : r_status_q;
          o_bytes_d   = r_bytes_q;
          o_hit_d     = r_hit_q;
          o_evc_d     = r_evc_q;
          o_cached_d  = r_cached_q;
          o_used_d    = used_q;
          o_count_d   = count_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      iss_q       <= '0;
      iss_done_q  <= 1'b0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      last_q      <= '0;
      used_q      <= '0;
      count_q     <= '0;
      budget_q    <= BudgetRst;
      maxent_q    <= MaxEntRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_q       <= iss_d;
      iss_done_q  <= iss_done_d;
      pend_q      <= pend_d;
      pidx_q      <= pidx_d;
      last_q      <= last_d;
      used_q      <= used_d;
      count_q     <= count_d;
      budget_q    <= budget_d;
      maxent_q    <= maxent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    off_q        <= off_d;
    size_q       <= size_d;
    n_q          <= n_d;
    fill_q       <= fill_d;
    now_q        <= now_d;
    best_found_q <= best_found_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    best_bytes_q <= best_bytes_d;
    wr_idx_q     <= wr_idx_d;
    wr_ent_q     <= wr_ent_d;
    r_status_q   <= r_status_d;
    r_bytes_q    <= r_bytes_d;
    r_hit_q      <= r_hit_d;
    r_evc_q      <= r_evc_d;
    r_cached_q   <= r_cached_d;
    o_status_q   <= o_status_d;
    o_bytes_q    <= o_bytes_d;
    o_hit_q      <= o_hit_d;
    o_evc_q      <= o_evc_d;
    o_cached_q   <= o_cached_d;
    o_used_q     <= o_used_d;
    o_count_q    <= o_count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = o_status_q;
  assign bytes_returned_o = o_bytes_q;
  assign hit_o            = o_hit_q;
  assign evicted_count_o  = CntOutW'(o_evc_q);
  assign cached_o         = o_cached_q;
  assign used_bytes_o     = o_used_q;
  assign entry_count_o    = CntOutW'(o_count_q);

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for region_cache_lru_tracker_top: directed and random requests
// checked beat by beat against an in-bench LRU cache predictor.
// Depends on rclt_pkg and the top level only.
`timescale 1ns / 1ps
module testbench;
  import rclt_pkg::*;

  localparam int unsigned NSLOT = EntriesDef;

  typedef struct {
    func_e              func;
    logic [KeyW-1:0]    key;
    logic [OffW-1:0]    off;
    logic [SizeW-1:0]   size;
    logic               fill;
    logic [SizeW-1:0]   fetched;
    logic [StampW-1:0]  now;
  } req_t;

  typedef struct {
    logic               status;
    logic [SizeW-1:0]   nbytes;
    logic               hit;
    logic [CntOutW-1:0] evicted;
    logic               cached;
    logic [UsedW-1:0]   used;
    logic [CntOutW-1:0] count;
  } res_t;

  class lru_scoreboard;
    bit                 slot_valid [NSLOT];
    logic [KeyW-1:0]    slot_key   [NSLOT];
    logic [OffW-1:0]    slot_off   [NSLOT];
    logic [SizeW-1:0]   slot_bytes [NSLOT];
    logic [StampW-1:0]  slot_stamp [NSLOT];
    logic [63:0]        bytes_held;
    int unsigned        held;
    logic [63:0]        budget;
    logic [CntOutW-1:0] max_ent;
    res_t               expected_q[$];
    int unsigned        errors;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 0;
      bytes_held = 0;
      held       = 0;
      budget     = 64'(BudgetRst);
      max_ent    = MaxEntRst;
      errors     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgBudget) budget = 64'(data);
      else if (idx == CfgMaxEnt) max_ent = data[CntOutW-1:0];
    endfunction

    function int unsigned slot_limit();
      if (max_ent == 0 || max_ent > NSLOT) return NSLOT;
      return max_ent;
    endfunction

    function int find(logic [KeyW-1:0] k, logic [OffW-1:0] o);
      for (int i = 0; i < NSLOT; i++)
        if (slot_valid[i] && slot_key[i] == k && slot_off[i] == o) return i;
      return -1;
    endfunction

    function bit drop_oldest();
      int          victim;
      logic [63:0] oldest;
      victim = -1;
      oldest = '1;
      if (held == 0) return 0;
      for (int i = 0; i < NSLOT; i++)
        if (slot_valid[i] && 64'(slot_stamp[i]) < oldest) begin
          oldest = 64'(slot_stamp[i]);
          victim = i;
        end
      if (victim < 0) return 0;
      if (bytes_held >= 64'(slot_bytes[victim])) bytes_held -= 64'(slot_bytes[victim]);
      else bytes_held = 0;
      slot_valid[victim] = 0;
      held--;
      return 1;
    endfunction

    function logic [SizeW-1:0] fill_miss(req_t r, bit fill, ref int unsigned nev);
      logic [SizeW-1:0] n;
      int unsigned      lim;
      lim = slot_limit();
      while (fill && bytes_held + 64'(r.size) > budget && held > 0) begin
        if (!drop_oldest()) break;
        nev++;
      end
      n = (r.fetched < r.size) ? r.fetched : r.size;
      if (n == 0) return 0;
      if (fill && held < lim)
        for (int i = 0; i < lim; i++)
          if (!slot_valid[i]) begin
            slot_valid[i] = 1;
            slot_key[i]   = r.key;
            slot_off[i]   = r.off;
            slot_bytes[i] = n;
            slot_stamp[i] = r.now;
            held++;
            bytes_held += 64'(n);
            if (bytes_held > 64'(UsedMax)) bytes_held = 64'(UsedMax);
            break;
          end
      return n;
    endfunction

    // accepted request beat: advance the model and queue its result
    function void note(req_t r);
      res_t        e;
      int          s;
      int unsigned nev;
      e   = '{default: '0};
      nev = 0;
      case (r.func)
        FnRead: if (r.size != 0) begin
          s = find(r.key, r.off);
          if (s >= 0) begin
            slot_stamp[s] = r.now;
            e.hit    = 1;
            e.nbytes = r.size;
          end else begin
            e.nbytes = fill_miss(r, r.fill, nev);
          end
        end
        FnPrefetch: begin
          if (r.size == 0) e.status = 1;
          else if (find(r.key, r.off) >= 0) e.hit = 1;
          else begin
            e.nbytes = fill_miss(r, 1'b1, nev);
            e.status = (e.nbytes == 0);
          end
        end
        FnQuery: begin
          for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && slot_key[i] == r.key) begin
              e.cached = 1;
              break;
            end
        end
        default: if (drop_oldest()) begin
          e.cached = 1;
          nev      = 1;
        end
      endcase
      e.evicted = nev[CntOutW-1:0];
      e.used    = bytes_held[UsedW-1:0];
      e.count   = held[CntOutW-1:0];
      expected_q.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] exp);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
      errors++;
    endtask

    task check(res_t g);
      res_t e;
      if (expected_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (g.status !== e.status)  report("status", g.status, e.status);
      if (g.nbytes !== e.nbytes)  report("bytes_returned", g.nbytes, e.nbytes);
      if (g.hit !== e.hit)        report("hit", g.hit, e.hit);
      if (g.evicted !== e.evicted) report("evicted_count", g.evicted, e.evicted);
      if (g.cached !== e.cached)  report("cached", g.cached, e.cached);
      if (g.used !== e.used)      report("used_bytes", g.used, e.used);
      if (g.count !== e.count)    report("entry_count", g.count, e.count);
    endtask
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                cfg_valid_i = 0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 0;
  logic                in_ready_o;
  logic [1:0]          func_i = '0;
  logic [KeyW-1:0]     name_key_i = '0;
  logic [OffW-1:0]     region_offset_i = '0;
  logic [SizeW-1:0]    region_size_i = '0;
  logic                cache_fill_i = 0;
  logic [SizeW-1:0]    fetched_bytes_i = '0;
  logic [StampW-1:0]   now_time_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 0;
  logic                status_o, hit_o, cached_o;
  logic [SizeW-1:0]    bytes_returned_o;
  logic [CntOutW-1:0]  evicted_count_o, entry_count_o;
  logic [UsedW-1:0]    used_bytes_o;

  region_cache_lru_tracker_top u_top (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  lru_scoreboard     sb = new();
  bit                quiet = 0;
  bit                hold_req = 0;
  logic [StampW-1:0] clock_ms = 48'd100;

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check('{status_o, bytes_returned_o, hit_o, evicted_count_o, cached_o,
                 used_bytes_o, entry_count_o});

  // result side: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 0;
        repeat (6000) @(posedge clk_i);
        hold_req = 0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_ready_i <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  task automatic send(req_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1;
    func_i          <= r.func;
    name_key_i      <= r.key;
    region_offset_i <= r.off;
    region_size_i   <= r.size;
    cache_fill_i    <= r.fill;
    fetched_bytes_i <= r.fetched;
    now_time_i      <= r.now;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note(r);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic req_t mk(func_e f, logic [KeyW-1:0] k, logic [OffW-1:0] o,
                              logic [SizeW-1:0] sz, logic fl, logic [SizeW-1:0] fb,
                              logic [StampW-1:0] t);
    req_t r;
    r = '{f, k, o, sz, fl, fb, t};
    return r;
  endfunction

  // mostly a small key/offset pool so hits and LRU churn happen; some full-width noise
  function automatic req_t rand_req(int unsigned maxsz);
    req_t r;
    int   p;
    p = $urandom_range(0, 99);
    r.func = (p < 40) ? FnRead : (p < 65) ? FnPrefetch : (p < 82) ? FnQuery : FnEvict;
    r.key  = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 7));
    r.off  = ($urandom_range(0, 9) == 0) ? {16'($urandom()), 32'($urandom())}
                                         : 48'($urandom_range(0, 3) * 4096);
    case ($urandom_range(0, 19))
      0:       r.size = 0;
      1:       r.size = $urandom();
      default: r.size = $urandom_range(1, maxsz);
    endcase
    r.fill = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 9))
      0:       r.fetched = 0;
      1:       r.fetched = $urandom();
      2:       r.fetched = $urandom_range(0, r.size);
      default: r.fetched = r.size;
    endcase
    if ($urandom_range(0, 49) == 0) r.now = {16'($urandom()), 32'($urandom())};
    else if ($urandom_range(0, 5) != 0) clock_ms += 48'($urandom_range(1, 50));
    r.now = (r.now === 'x || r.now == 0) ? clock_ms : r.now;
    return r;
  endfunction

  task automatic random_phase(int unsigned n, int unsigned maxsz);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r.now = 0;
      r = rand_req(maxsz);
      send(r);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;

    // directed: every operation and the corner cases
    send(mk(FnRead, 32'd1, 48'd0, 32'd100, 1, 32'd100, 48'd10));      // miss, insert
    send(mk(FnRead, 32'd1, 48'd0, 32'd7, 0, 32'd0, 48'd11));          // hit
    send(mk(FnRead, 32'd1, 48'd0, 32'd0, 1, 32'd5, 48'd12));          // zero size
    send(mk(FnRead, 32'd2, 48'd8, 32'd50, 0, 32'd50, 48'd13));        // miss without fill
    send(mk(FnRead, 32'd2, 48'd8, 32'd50, 1, 32'd900, 48'd13));       // clamped fetch
    send(mk(FnRead, 32'd3, 48'd8, 32'd60, 1, 32'd0, 48'd13));         // failed fetch
    send(mk(FnPrefetch, 32'd1, 48'd0, 32'd10, 0, 32'd10, 48'd14));    // prefetch hit
    send(mk(FnPrefetch, 32'd4, 48'd16, 32'd30, 0, 32'd20, 48'd14));   // prefetch miss
    send(mk(FnPrefetch, 32'd5, 48'd16, 32'd0, 0, 32'd20, 48'd15));    // zero size
    send(mk(FnPrefetch, 32'd5, 48'd16, 32'd40, 1, 32'd0, 48'd15));    // failed fetch
    send(mk(FnQuery, 32'd1, 48'd99, 32'd0, 0, 32'd0, 48'd16));
    send(mk(FnQuery, 32'd9, 48'd0, 32'd0, 0, 32'd0, 48'd16));
    send(mk(FnEvict, 32'd0, 48'd0, 32'd0, 0, 32'd0, 48'd17));         // evicts the oldest entry, stamp 11
    send(mk(FnRead, '1, '1, '1, 1, '1, '1));                          // whole budget blown
    send(mk(FnQuery, '1, '1, '1, 1, '1, '1));
    send(mk(FnEvict, '1, '1, '1, 1, '1, '1));
    send(mk(FnEvict, 32'd0, 48'd0, 32'd0, 0, 32'd0, 48'd18));         // empty cache
    send(mk(FnPrefetch, 32'd6, 48'd0, 32'd5, 1, 32'd5, 48'd20));
    send(mk(FnPrefetch, 32'd7, 48'd0, 32'd5, 1, 32'd5, 48'd20));      // equal stamps
    send(mk(FnEvict, 32'd0, 48'd0, 32'd0, 0, 32'd0, 48'd21));

    // default registers, with one long hold-off on the result side
    random_phase(40, 4000);
    hold_req = 1;
    random_phase(110, 4000);
    drain();

    write_reg(CfgBudget, 48'd3000);
    write_reg(CfgMaxEnt, 48'd6);
    random_phase(140, 1500);
    drain();

    write_reg(CfgBudget, 48'd0);
    write_reg(CfgMaxEnt, 48'd1);
    random_phase(60, 200);
    drain();

    write_reg(CfgBudget, {CfgDataW{1'b1}});
    write_reg(CfgMaxEnt, 48'd2047);                                   // above range
    random_phase(100, 1000);
    drain();

    write_reg(CfgBudget, 48'd5000);
    write_reg(CfgMaxEnt, 48'd0);                                      // zero acts as full size
    random_phase(30, 800);
    quiet = 1;
    random_phase(80, 800);
    drain();

    if (sb.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
